>>> rtl/acs_pkg.sv
// acs_pkg: shared widths, codes and types for the sorted assignment population
// used by the interfaces, the cost table unit and the top level
`default_nettype none

package acs_pkg;

  localparam int GENE_W    = 4;
  localparam int CAND_W    = 64;
  localparam int COST_W    = 7;
  localparam int SUM_W     = 11;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int REQ_W     = 2;
  localparam int IDX_W     = 4;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_READ   = 2'd2
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_GENE = 2'd1,
    STAT_BAD_RANK = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_TASKS = 2'd0,
    CFG_NUM_PROCS = 2'd1,
    CFG_POP_SIZE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_WREAD,
    S_WCMP,
    S_RADR,
    S_RDAT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             done;
    logic             bad;
    logic [SUM_W-1:0] sum;
  } sum_stat_t;

endpackage

`default_nettype wire

>>> rtl/acs_if.sv
// acs_req_if / acs_rsp_if: valid-ready channels for request and response words
// depends on acs_pkg for field widths
`default_nettype none

interface acs_req_if import acs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [IDX_W-1:0]    task_index;
  logic [IDX_W-1:0]    proc_index;
  logic [COST_W-1:0]   cost_value;
  logic [CAND_W-1:0]   candidate;
  logic [IDX_W-1:0]    rank;

  modport source (
    output valid, req_type, task_index, proc_index, cost_value, candidate, rank,
    input  ready
  );
  modport sink (
    input  valid, req_type, task_index, proc_index, cost_value, candidate, rank,
    output ready
  );
endinterface

interface acs_rsp_if import acs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [SUM_W-1:0]    total_cost;
  logic [CAND_W-1:0]   entry_genes;
  logic [CNT_W-1:0]    entry_count;

  modport source (
    output valid, status, total_cost, entry_genes, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, total_cost, entry_genes, entry_count,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/acs_ram.sv
// acs_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module acs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/acs_cost.sv
// acs_cost: task-to-processor cost table and gene-by-gene cost summer
// depends on acs_pkg and acs_ram
`default_nettype none

module acs_cost
  import acs_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int MAX_PROCS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_task_i,
  input  logic [IDX_W-1:0]  wr_proc_i,
  input  logic [COST_W-1:0] wr_cost_i,
  input  logic              start_i,
  input  logic [CAND_W-1:0] cand_i,
  input  logic [CFG_W-1:0]  num_tasks_i,
  input  logic [CFG_W-1:0]  num_procs_i,
  output sum_stat_t         stat_o
);

  localparam int TW     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int PW     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CAW    = TW + PW;
  localparam int CDEPTH = 2 ** CAW;

  logic              busy_q, pend_q, done_q, bad_q;
  logic [CFG_W-1:0]  t_q;
  logic [SUM_W-1:0]  acc_q, acc_d;
  logic [CFG_W-1:0]  nt, np;
  logic [GENE_W-1:0] gene;
  logic              issue, stop, in_range;
  logic              tbl_we;
  logic [CAW-1:0]    tbl_waddr, tbl_raddr;
  logic [COST_W-1:0] tbl_rdata;

  always_comb begin
    nt = (32'(num_tasks_i) > MAX_TASKS) ? CFG_W'(MAX_TASKS) : num_tasks_i;
    np = (32'(num_procs_i) > MAX_PROCS) ? CFG_W'(MAX_PROCS) : num_procs_i;
    gene = cand_i[GENE_W*t_q[IDX_W-1:0] +: GENE_W];
    in_range = (t_q < nt);
    issue = busy_q && in_range && ({1'b0, gene} < np);
    stop = busy_q && !issue;
    acc_d = acc_q + (pend_q ? SUM_W'(tbl_rdata) : '0);
    tbl_raddr = {t_q[TW-1:0], gene[PW-1:0]};
    tbl_we = wr_en_i && (32'(wr_task_i) < MAX_TASKS) && (32'(wr_proc_i) < MAX_PROCS);
    tbl_waddr = {wr_task_i[TW-1:0], wr_proc_i[PW-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      done_q <= 1'b0;
      bad_q  <= 1'b0;
      t_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      pend_q <= 1'b0;
      done_q <= 1'b0;
      bad_q  <= 1'b0;
      t_q    <= '0;
    end else begin
      pend_q <= issue;
      done_q <= stop;
      if (issue) begin
        t_q <= t_q + CFG_W'(1);
      end
      if (stop) begin
        busy_q <= 1'b0;
        bad_q  <= in_range;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  acs_ram #(
    .WIDTH (COST_W),
    .DEPTH (CDEPTH)
  ) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (wr_cost_i),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  assign stat_o = '{done: done_q, bad: bad_q, sum: acc_q};

endmodule

`default_nettype wire

>>> rtl/assignment_cost_sorted_population_top.sv
// one request in flight: a cost write, read or insert runs from acceptance to the response
// word, and the next request is taken once the previous result is loaded into the output
// register
// insert time is set by one cost ram read per task and one population ram entry per step
// reset: asynchronous active low, config registers go to 16, population count to zero
`default_nettype none

module assignment_cost_sorted_population_top
  import acs_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int MAX_PROCS = 16,
  parameter int POP_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  acs_req_if.sink              req_i,
  acs_rsp_if.source            rsp_o
);

  localparam int AW = $clog2(POP_DEPTH);
  localparam int CW = $clog2(POP_DEPTH + 1);
  localparam int EW = SUM_W + CAND_W;

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  num_tasks_q, num_procs_q, pop_size_q;
  logic [REQ_W-1:0]  req_q;
  logic [CAND_W-1:0] cand_q;
  logic [IDX_W-1:0]  rank_q;
  logic [CW-1:0]     held_q, held_d;
  logic [AW-1:0]     k_q, k_d;
  logic [CW-1:0]     cap;

  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [SUM_W-1:0]  res_total_q, res_total_d;
  logic [CAND_W-1:0] res_genes_q, res_genes_d;

  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q;
  logic [SUM_W-1:0]  out_total_q;
  logic [CAND_W-1:0] out_genes_q;
  logic [CNT_W-1:0]  out_count_q;
  logic              out_load;

  logic              accept;
  sum_stat_t         sum_stat;
  logic              pop_we;
  logic [AW-1:0]     pop_waddr, pop_raddr;
  logic [EW-1:0]     pop_wdata, pop_rdata;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    if (32'(pop_size_q) > POP_DEPTH) begin
      cap = CW'(POP_DEPTH);
    end else if (pop_size_q < CFG_W'(2)) begin
      cap = CW'(2);
    end else begin
      cap = CW'(pop_size_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_tasks_q <= CFG_RESET;
      num_procs_q <= CFG_RESET;
      pop_size_q  <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_TASKS: num_tasks_q <= cfg_data_i;
        CFG_NUM_PROCS: num_procs_q <= cfg_data_i;
        CFG_POP_SIZE:  pop_size_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  acs_cost #(
    .MAX_TASKS (MAX_TASKS),
    .MAX_PROCS (MAX_PROCS)
  ) u_cost (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (accept && (req_i.req_type == REQ_WRITE)),
    .wr_task_i   (req_i.task_index),
    .wr_proc_i   (req_i.proc_index),
    .wr_cost_i   (req_i.cost_value),
    .start_i     (accept && (req_i.req_type == REQ_INSERT)),
    .cand_i      (cand_q),
    .num_tasks_i (num_tasks_q),
    .num_procs_i (num_procs_q),
    .stat_o      (sum_stat)
  );

  acs_ram #(
    .WIDTH (EW),
    .DEPTH (POP_DEPTH)
  ) u_pop_ram (
    .clk_i   (clk_i),
    .we_i    (pop_we),
    .waddr_i (pop_waddr),
    .wdata_i (pop_wdata),
    .raddr_i (pop_raddr),
    .rdata_o (pop_rdata)
  );

  always_comb begin
    logic [CW-1:0] h;
    h            = (held_q >= cap) ? (cap - CW'(1)) : held_q;
    state_d      = state_q;
    held_d       = held_q;
    k_d          = k_q;
    res_status_d = res_status_q;
    res_total_d  = res_total_q;
    res_genes_d  = res_genes_q;
    pop_we       = 1'b0;
    pop_waddr    = k_q;
    pop_wdata    = {sum_stat.sum, cand_q};
    pop_raddr    = k_q - AW'(1);
    out_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = STAT_OK;
          res_total_d  = '0;
          res_genes_d  = '0;
          case (req_i.req_type)
            REQ_INSERT: state_d = S_SUM;
            REQ_READ:   state_d = S_RADR;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_SUM: begin
        if (sum_stat.done) begin
          if (sum_stat.bad) begin
            res_status_d = STAT_BAD_GENE;
            state_d      = S_DONE;
          end else begin
            held_d      = h + CW'(1);
            k_d         = AW'(h);
            res_total_d = sum_stat.sum;
            state_d     = S_WREAD;
          end
        end
      end
      S_WREAD: begin
        if (k_q == '0) begin
          pop_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_WCMP;
        end
      end
      S_WCMP: begin
        pop_we = 1'b1;
        if (pop_rdata[EW-1:CAND_W] >= sum_stat.sum) begin
          // shift entry up one rank and keep walking down
          pop_wdata = pop_rdata;
          pop_raddr = k_q - AW'(2);
          k_d       = k_q - AW'(1);
          if (k_q == AW'(1)) begin
            state_d = S_WREAD;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_RADR: begin
        pop_raddr = AW'(rank_q);
        state_d   = S_RDAT;
      end
      S_RDAT: begin
        if (32'(rank_q) >= 32'(held_q)) begin
          res_status_d = STAT_BAD_RANK;
        end else begin
          res_total_d = pop_rdata[EW-1:CAND_W];
          res_genes_d = pop_rdata[CAND_W-1:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q && !rsp_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    res_status_q <= res_status_d;
    res_total_q  <= res_total_d;
    res_genes_q  <= res_genes_d;
    if (accept) begin
      req_q  <= req_i.req_type;
      cand_q <= req_i.candidate;
      rank_q <= req_i.rank;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_total_q  <= res_total_q;
      out_genes_q  <= res_genes_q;
      out_count_q  <= CNT_W'(held_q);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.total_cost  = out_total_q;
  assign rsp_o.entry_genes = out_genes_q;
  assign rsp_o.entry_count = out_count_q;

`ifndef SYNTHESIS
  a_held_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(POP_DEPTH))
    else $error("population count beyond depth");

  a_sum_done_in_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_stat.done |-> (state_q == S_SUM))
    else $error("cost sum finished outside sum phase");

  a_walk_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WCMP) |-> (k_q != '0))
    else $error("insert walk compare at rank zero");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SUM) && sum_stat.done && !sum_stat.bad) |=>
      ((held_q != '0) && (held_q <= cap) && (req_q == REQ_INSERT)))
    else $error("insert left population count out of range");
`endif

endmodule

`default_nettype wire
